// ===== hw/rtl/robin_hood_hash_table_assert.svh =====
// Assertion macros shared by the hash table RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RHH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHH_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RHH_ASSERT(lbl, clk, rst, prop, msg)
`define RHH_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== hw/rtl/rhh_pkg.sv =====
// Types and constants of the Robin Hood hash table.
// No dependencies.
`default_nettype none
package rhh_pkg;
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

   localparam logic [9:0] FILL_LIMIT_RESET = 10'd921;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [63:0] value;
   } task_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] read_value;
      logic [10:0] entry_count;
   } result_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_MUL,
      H_MOD,
      H_PUSH
   } hash_state_type;

   typedef enum logic [2:0] {
      E_CLEAR,
      E_IDLE,
      E_PROBE,
      E_PLACE,
      E_SHIFT,
      E_DONE
   } engine_state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rhh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module rhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/rhh_fifo.sv =====
// Small register queue with full and empty flags.
// No dependencies.
`default_nettype none
module rhh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == DEPTH_C;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rhh_front.sv =====
// Front end: accepts requests, hashes the key and reduces it to a home bucket.
// Depends on rhh_pkg.
`default_nettype none
module rhh_front #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        hold,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [1:0]                  req_action,
   input  wire logic [63:0]                 req_key,
   input  wire logic [63:0]                 req_value,
   output rhh_pkg::task_type                task_out,
   output logic [$clog2(CAPACITY)-1:0]      home_out,
   output logic                             q_push,
   input  wire logic                        q_full
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int REM_W = IDX_W + 1;
   localparam logic [REM_W-1:0] CAP_R = REM_W'(CAPACITY);

   rhh_pkg::hash_state_type state_ff, state_in;
   rhh_pkg::task_type       task_ff, task_in;
   logic [63:0]             x_ff, x_in, acc_ff, acc_in, cst;
   logic [1:0]              step_ff, step_in;
   logic                    round_ff, round_in;
   logic [2:0]              byte_ff, byte_in;
   logic [REM_W-1:0]        rem_ff, rem_in, rem_t;
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             prod;
   logic                    accept;

   assign req_full = (state_ff != rhh_pkg::H_IDLE) || hold;
   assign accept   = req_push && !req_full;
   assign cst      = round_ff ? rhh_pkg::MIX_MUL_B : rhh_pkg::MIX_MUL_A;
   assign mul_a    = (step_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b    = (step_ff == 2'd2) ? cst[63:32] : cst[31:0];
   assign prod     = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhh_pkg::H_IDLE: if (accept) state_in = rhh_pkg::H_MUL;
         rhh_pkg::H_MUL:  if (step_ff == 2'd3 && round_ff) state_in = rhh_pkg::H_MOD;
         rhh_pkg::H_MOD:  if (byte_ff == 3'd7) state_in = rhh_pkg::H_PUSH;
         rhh_pkg::H_PUSH: if (!q_full) state_in = rhh_pkg::H_IDLE;
         default:         state_in = rhh_pkg::H_IDLE;
      endcase
   end

   always_comb begin
      task_in  = task_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      round_in = round_ff;
      byte_in  = byte_ff;
      rem_in   = rem_ff;
      rem_t    = rem_ff;
      q_push   = 1'b0;
      case (state_ff)
         rhh_pkg::H_IDLE: begin
            if (accept) begin
               task_in.action = req_action;
               task_in.key    = req_key;
               task_in.value  = req_value;
               x_in     = (req_key >> rhh_pkg::MIX_SHIFT_A) ^ req_key;
               step_in  = 2'd0;
               round_in = 1'b0;
            end
         end
         rhh_pkg::H_MUL: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0:    acc_in = prod;
               2'd1,
               2'd2:    acc_in = acc_ff + {prod[31:0], 32'd0};
               default: begin
                  if (!round_ff) begin
                     x_in     = (acc_ff >> rhh_pkg::MIX_SHIFT_B) ^ acc_ff;
                     round_in = 1'b1;
                  end else begin
                     x_in    = (acc_ff >> rhh_pkg::MIX_SHIFT_C) ^ acc_ff;
                     rem_in  = '0;
                     byte_in = 3'd0;
                  end
               end
            endcase
         end
         rhh_pkg::H_MOD: begin
            for (int b = 0; b < 8; b++) begin
               rem_t = {rem_t[REM_W-2:0], x_ff[63-b]};
               if (rem_t >= CAP_R) begin
                  rem_t = rem_t - CAP_R;
               end
            end
            rem_in  = rem_t;
            x_in    = {x_ff[55:0], 8'd0};
            byte_in = byte_ff + 3'd1;
         end
         rhh_pkg::H_PUSH: begin
            q_push = !q_full;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhh_pkg::H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      task_ff  <= task_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
      round_ff <= round_in;
      byte_ff  <= byte_in;
      rem_ff   <= rem_in;
   end

   assign task_out = task_ff;
   assign home_out = rem_ff[IDX_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/rhh_engine.sv =====
// Back end: probes, inserts with displacement and removes with backward shift.
// Depends on rhh_pkg, rhh_ram and the assertion header.
`default_nettype none
`include "robin_hood_hash_table_assert.svh"
module rhh_engine #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [9:0]                  fill_limit,
   input  wire rhh_pkg::task_type           q_task,
   input  wire logic [$clog2(CAPACITY)-1:0] q_home,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   input  wire logic                        out_full,
   output logic                             out_push,
   output rhh_pkg::result_type              out_result,
   output logic                             clearing
);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int OFF_W  = IDX_W + 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = ((CNT_W > 10) ? CNT_W : 10) + 1;
   localparam int WORD_W = 1 + IDX_W + 128;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(CAPACITY - 1);
   localparam logic [CMP_W-1:0] CAP_X    = CMP_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

   rhh_pkg::engine_state_type state_ff, state_in;
   logic [1:0]        act_ff, act_in, status_ff, status_in;
   logic [63:0]       key_ff, key_in, val_ff, val_in, rv_ff, rv_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, pos_ff, pos_in, clr_ff, clr_in, idx_nx;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic              rd_valid;
   logic [IDX_W-1:0]  rd_dist;
   logic [63:0]       rd_key, rd_val;
   logic              is_hole, is_swap, is_match, is_last, probe_end, shift_end, refuse;
   logic [CMP_W-1:0]  count_x;
   logic              take;

   rhh_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign {rd_valid, rd_dist, rd_key, rd_val} = rd_data;
   assign idx_nx    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign is_hole   = !rd_valid;
   assign is_swap   = rd_valid && ({1'b0, rd_dist} < off_ff);
   assign is_match  = rd_valid && !is_swap && (rd_key == key_ff);
   assign is_last   = off_ff == LAST_OFF;
   assign probe_end = is_hole || is_swap || is_match || is_last;
   assign shift_end = is_last || !rd_valid || (rd_dist == '0);
   assign count_x   = CMP_W'(count_ff);
   assign refuse    = (count_x > CMP_W'(fill_limit)) || ((count_x + 1'b1) >= CAP_X);
   assign take      = (state_ff == rhh_pkg::E_IDLE) && !q_empty && !out_full;
   assign clearing  = state_ff == rhh_pkg::E_CLEAR;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhh_pkg::E_CLEAR: if (clr_ff == LAST_IDX) state_in = rhh_pkg::E_IDLE;
         rhh_pkg::E_IDLE: begin
            if (take) begin
               if (q_task.action == rhh_pkg::ACT_UNUSED) state_in = rhh_pkg::E_DONE;
               else state_in = rhh_pkg::E_PROBE;
            end
         end
         rhh_pkg::E_PROBE: begin
            if (probe_end) begin
               if (act_ff == rhh_pkg::ACT_REMOVE && is_match) begin
                  state_in = rhh_pkg::E_SHIFT;
               end else if (act_ff == rhh_pkg::ACT_INSERT && is_swap && !refuse) begin
                  state_in = rhh_pkg::E_PLACE;
               end else begin
                  state_in = rhh_pkg::E_DONE;
               end
            end
         end
         rhh_pkg::E_PLACE: if (is_hole) state_in = rhh_pkg::E_DONE;
         rhh_pkg::E_SHIFT: if (shift_end) state_in = rhh_pkg::E_DONE;
         rhh_pkg::E_DONE:  state_in = rhh_pkg::E_IDLE;
         default:          state_in = rhh_pkg::E_IDLE;
      endcase
   end

   always_comb begin
      act_in    = act_ff;
      status_in = status_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      rv_in     = rv_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      clr_in    = clr_ff;
      off_in    = off_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = '0;
      q_pop     = 1'b0;
      out_push  = 1'b0;
      case (state_ff)
         rhh_pkg::E_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         rhh_pkg::E_IDLE: begin
            if (take) begin
               q_pop     = 1'b1;
               act_in    = q_task.action;
               key_in    = q_task.key;
               val_in    = q_task.value;
               idx_in    = q_home;
               off_in    = '0;
               rv_in     = '0;
               status_in = rhh_pkg::STATUS_MISS;
            end
         end
         rhh_pkg::E_PROBE: begin
            if (!probe_end) begin
               off_in = off_ff + 1'b1;
               idx_in = idx_nx;
            end else if (act_ff == rhh_pkg::ACT_SEARCH) begin
               if (is_match) begin
                  rv_in     = rd_val;
                  status_in = rhh_pkg::STATUS_OK;
               end
            end else if (act_ff == rhh_pkg::ACT_REMOVE) begin
               if (is_match) begin
                  pos_in = idx_ff;
                  idx_in = idx_nx;
                  off_in = '0;
               end
            end else if (is_match) begin
               wr_en     = 1'b1;
               wr_data   = {1'b1, rd_dist, key_ff, val_ff};
               status_in = rhh_pkg::STATUS_OK;
            end else if (is_hole) begin
               wr_en     = 1'b1;
               wr_data   = {1'b1, off_ff[IDX_W-1:0], key_ff, val_ff};
               count_in  = count_ff + 1'b1;
               status_in = rhh_pkg::STATUS_OK;
            end else if (refuse) begin
               status_in = rhh_pkg::STATUS_FULL;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = rhh_pkg::STATUS_OK;
               if (is_swap) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, off_ff[IDX_W-1:0], key_ff, val_ff};
                  key_in  = rd_key;
                  val_in  = rd_val;
                  off_in  = {1'b0, rd_dist} + 1'b1;
                  idx_in  = idx_nx;
               end
            end
         end
         rhh_pkg::E_PLACE: begin
            if (is_hole) begin
               wr_en   = 1'b1;
               wr_data = {1'b1, off_ff[IDX_W-1:0], key_ff, val_ff};
            end else begin
               idx_in = idx_nx;
               if (is_swap) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, off_ff[IDX_W-1:0], key_ff, val_ff};
                  key_in  = rd_key;
                  val_in  = rd_val;
                  off_in  = {1'b0, rd_dist} + 1'b1;
               end else begin
                  off_in = off_ff + 1'b1;
               end
            end
         end
         rhh_pkg::E_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (shift_end) begin
               wr_data   = '0;
               count_in  = count_ff - 1'b1;
               status_in = rhh_pkg::STATUS_OK;
            end else begin
               wr_data = {1'b1, rd_dist - 1'b1, rd_key, rd_val};
               pos_in  = idx_ff;
               idx_in  = idx_nx;
               off_in  = off_ff + 1'b1;
            end
         end
         rhh_pkg::E_DONE: begin
            out_push = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhh_pkg::E_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      act_ff    <= act_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      rv_ff     <= rv_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      off_ff    <= off_in;
   end

   assign out_result.status      = status_ff;
   assign out_result.read_value  = rv_ff;
   assign out_result.entry_count = 11'(count_ff);

   `RHH_NEVER(a_count_range, clock, reset, count_ff > CAP_CNT, "entry count above capacity")
   `RHH_ASSERT(a_push_room, clock, reset, out_push |-> !out_full, "result pushed into full queue")
   `RHH_ASSERT(a_no_pop_clear, clock, reset, clearing |-> !q_pop, "item taken during clear")
   `RHH_ASSERT(a_pop_leaves_idle, clock, reset, q_pop |=> state_ff != rhh_pkg::E_IDLE, "pop without work")
endmodule
`default_nettype wire

// ===== hw/rtl/robin_hood_hash_table.sv =====
// Robin Hood hash table: hashing front end, two-entry task queue, probing back end.
// Flow: the front end hashes the key and reduces it into the task queue; the back end then
// probes and places or shifts, one bucket per cycle through the slot memory.
// The front end takes a new request only once the last is pushed, paced by the shared 32x32
// multiplier and the byte-wise modulo; the back end is paced by long probe chains.
// Reset: synchronous; afterwards a clearing pass empties every slot.
`default_nettype none
module robin_hood_hash_table #(
   parameter int CAPACITY = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_action,
   input  wire logic [63:0] req_key,
   input  wire logic [63:0] req_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_read_value,
   output logic [10:0]      rsp_entry_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [9:0]  csr_data
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int MID_W = $bits(rhh_pkg::task_type) + IDX_W;
   localparam int OUT_W = $bits(rhh_pkg::result_type);

   logic [9:0]          fill_limit_ff, fill_limit_in;
   rhh_pkg::task_type   front_task, q_task;
   logic [IDX_W-1:0]    front_home, q_home;
   logic                mid_push, mid_full, mid_pop, mid_empty;
   logic [MID_W-1:0]    mid_out;
   logic                out_push, out_full, clearing;
   rhh_pkg::result_type eng_result, rsp_result;
   logic [OUT_W-1:0]    rsp_vec;

   assign csr_ready     = 1'b1;
   assign fill_limit_in = (csr_valid && csr_ready) ? csr_data : fill_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= rhh_pkg::FILL_LIMIT_RESET;
      end else begin
         fill_limit_ff <= fill_limit_in;
      end
   end

   rhh_front #(.CAPACITY(CAPACITY)) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_action (req_action),
      .req_key    (req_key),
      .req_value  (req_value),
      .task_out   (front_task),
      .home_out   (front_home),
      .q_push     (mid_push),
      .q_full     (mid_full)
   );

   rhh_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data ({front_task, front_home}),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   assign {q_task, q_home} = mid_out;

   rhh_engine #(.CAPACITY(CAPACITY)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fill_limit (fill_limit_ff),
      .q_task     (q_task),
      .q_home     (q_home),
      .q_empty    (mid_empty),
      .q_pop      (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (eng_result),
      .clearing   (clearing)
   );

   rhh_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (eng_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_result      = rsp_vec;
   assign rsp_status      = rsp_result.status;
   assign rsp_read_value  = rsp_result.read_value;
   assign rsp_entry_count = rsp_result.entry_count;
endmodule
`default_nettype wire
